// File: hdl/imm_pkg.sv
// Shared constants and types for the integer matrix multiply block.
`default_nettype none
package imm_pkg;

    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int FIELD_W = 16;
    localparam int DOT_W   = 35;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    localparam logic [1:0] ACT_WRITE_A  = 2'd0;
    localparam logic [1:0] ACT_WRITE_B  = 2'd1;
    localparam logic [1:0] ACT_MULTIPLY = 2'd2;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic             first;
        logic             dot_end;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage
`default_nettype wire

// File: hdl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiply block with its element stores and MAC sequencer.
//
//  Channel  Direction  Handshake            Contents
//  s_       in         s_tvalid/s_tready    element write or multiply command
//  m_       out        m_tvalid/m_tready    one element of the product, tlast on the final one
//  cfg_     in         cfg_valid/cfg_ready  size register writes
//
// A multiply issues one product per cycle through the single multiplier and accumulator while
// the output is not stalled, then drains the pipeline before it returns to idle.
// A full output register that is not taken stalls the whole product pipeline.
// Reset is synchronous and active low; the element stores are not cleared.
`default_nettype none
module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // elem_row [2:0], elem_col [5:3], elem_value [21:6], zero [23:22]
    input  wire logic [imm_pkg::S_DATA_W-1:0]  s_tdata,
    // action [1:0]
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_row [2:0], out_col [5:3], dot_value [40:6], zero [47:41]
    output logic [imm_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [imm_pkg::DIM_W-1:0]     cfg_data
);
    import imm_pkg::*;

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PROD_W = 2 * DATA_WIDTH;

    function automatic logic [IDX_W-1:0] dim_lim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return '0;
        end
        if (int'(d) > MAX_DIM) begin
            return IDX_W'(MAX_DIM - 1);
        end
        return IDX_W'(d - DIM_W'(1));
    endfunction

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0] lim_m_reg, lim_k_reg, lim_p_reg;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, t_reg, t_next;

    logic signed [DATA_WIDTH-1:0] mem_a [STORE_DEPTH];
    logic signed [DATA_WIDTH-1:0] mem_b [STORE_DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [DOT_W-1:0]      acc_reg;
    logic signed [DOT_W-1:0]      sum;

    logic        v1_reg, v2_reg;
    tag_t        tag0, tag1_reg, tag2_reg;
    logic        issue, stall, start;

    logic [IDX_W-1:0]           in_row, in_col;
    logic signed [FIELD_W-1:0]  in_value;
    logic                       wr_ok, wr_a, wr_b;
    logic [ADDR_W-1:0]          wr_addr, a_addr, b_addr;

    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic [IDX_W-1:0]     out_row_reg, out_col_reg;
    logic [DOT_W-1:0]     out_dot_reg;

    assign in_row   = s_tdata[2:0];
    assign in_col   = s_tdata[5:3];
    assign in_value = s_tdata[21:6];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign stall     = out_valid_reg && !m_tready;
    assign start     = s_tvalid && s_tready && (s_tuser == ACT_MULTIPLY);

    assign wr_ok   = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign wr_a    = s_tvalid && s_tready && (s_tuser == ACT_WRITE_A) && wr_ok;
    assign wr_b    = s_tvalid && s_tready && (s_tuser == ACT_WRITE_B) && wr_ok;
    assign wr_addr = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
    assign a_addr  = ADDR_W'(int'(i_reg) * MAX_DIM + int'(t_reg));
    assign b_addr  = ADDR_W'(int'(t_reg) * MAX_DIM + int'(j_reg));

    always_comb begin
        tag0.first   = (t_reg == '0);
        tag0.dot_end = (t_reg == lim_k_reg);
        tag0.last    = (t_reg == lim_k_reg) && (j_reg == lim_p_reg) && (i_reg == lim_m_reg);
        tag0.row     = i_reg;
        tag0.col     = j_reg;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    t_next     = '0;
                end
            end
            ST_RUN: begin
                issue = !stall;
                if (!stall) begin
                    if (t_reg == lim_k_reg) begin
                        t_next = '0;
                        if (j_reg == lim_p_reg) begin
                            j_next = '0;
                            if (i_reg == lim_m_reg) begin
                                i_next     = '0;
                                state_next = ST_DRAIN;
                            end else begin
                                i_next = i_reg + IDX_W'(1);
                            end
                        end else begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end else begin
                        t_next = t_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_a_reg    <= DIM_W'(3);
            inner_dim_reg <= DIM_W'(3);
            cols_b_reg    <= DIM_W'(5);
            i_reg         <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            t_reg     <= t_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ROWS_A) begin
                    rows_a_reg <= cfg_data;
                end
                if (cfg_index == REG_INNER_DIM) begin
                    inner_dim_reg <= cfg_data;
                end
                if (cfg_index == REG_COLS_B) begin
                    cols_b_reg <= cfg_data;
                end
            end
            if (!stall) begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
            end
            if (v2_reg && tag2_reg.dot_end && !stall) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lim_m_reg <= dim_lim(rows_a_reg);
            lim_k_reg <= dim_lim(inner_dim_reg);
            lim_p_reg <= dim_lim(cols_b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[wr_addr] <= DATA_WIDTH'(in_value);
        end
        if (!stall) begin
            rd_a_reg <= mem_a[a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[wr_addr] <= DATA_WIDTH'(in_value);
        end
        if (!stall) begin
            rd_b_reg <= mem_b[b_addr];
        end
    end

    assign sum = (tag2_reg.first ? DOT_W'(0) : acc_reg) + DOT_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!stall) begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
            prod_reg <= PROD_W'(rd_a_reg) * PROD_W'(rd_b_reg);
            if (v2_reg) begin
                acc_reg <= sum;
            end
            if (v2_reg && tag2_reg.dot_end) begin
                out_row_reg  <= tag2_reg.row;
                out_col_reg  <= tag2_reg.col;
                out_dot_reg  <= sum;
                out_last_reg <= tag2_reg.last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(M_DATA_W - DOT_W - 2 * IDX_W)'(0), out_dot_reg, out_col_reg, out_row_reg};

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!v1_reg && !v2_reg))
        else $error("Input taken while products are still in flight.");

    a_last_ends_dot: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && tag2_reg.last) |-> tag2_reg.dot_end)
        else $error("Final element marked on a partial sum.");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |->
            (t_reg <= lim_k_reg && j_reg <= lim_p_reg && i_reg <= lim_m_reg))
        else $error("Sequencer counter beyond the configured size.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (stall && v2_reg) |=> (v2_reg && $stable(acc_reg)))
        else $error("Accumulator moved while the output was stalled.");

endmodule
`default_nettype wire

// File: tb/imm_product_checker.sv
// Channel monitor that predicts every product element and compares it with the block's results.
module imm_product_checker #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [imm_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [imm_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic                          m_tlast,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [imm_pkg::DIM_W-1:0]     cfg_data,
    output int                                 error_count,
    output int                                 pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [DOT_W-1:0] dot;
        logic             last;
    } product_elem_t;

    logic signed [FIELD_W-1:0] elems_a [MAX_DIM*MAX_DIM];
    logic signed [FIELD_W-1:0] elems_b [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]          size_rows;
    logic [DIM_W-1:0]          size_inner;
    logic [DIM_W-1:0]          size_cols;
    product_elem_t             product_q [$];
    logic [2*IDX_W-1:0]        slot;

    assign slot = {s_tdata[IDX_W-1:0], s_tdata[2*IDX_W-1:IDX_W]};

    task automatic report(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic int unsigned clamp_size(input logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return d;
    endfunction

    task automatic predict_product();
        int unsigned   m;
        int unsigned   k;
        int unsigned   p;
        longint        sum;
        product_elem_t elem;
        m = clamp_size(size_rows);
        k = clamp_size(size_inner);
        p = clamp_size(size_cols);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
                sum = 0;
                for (int t = 0; t < k; t++) begin
                    sum += longint'(elems_a[i*MAX_DIM + t]) * longint'(elems_b[t*MAX_DIM + j]);
                end
                elem.row  = IDX_W'(i);
                elem.col  = IDX_W'(j);
                elem.dot  = DOT_W'(sum);
                elem.last = (i == m - 1) && (j == p - 1);
                product_q.push_back(elem);
            end
        end
    endtask

    task automatic check_result();
        product_elem_t    want;
        logic [IDX_W-1:0] got_row;
        logic [IDX_W-1:0] got_col;
        logic [DOT_W-1:0] got_dot;
        got_row = m_tdata[IDX_W-1:0];
        got_col = m_tdata[2*IDX_W-1:IDX_W];
        got_dot = m_tdata[2*IDX_W +: DOT_W];
        if (product_q.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d", got_row, got_col));
        end else begin
            want = product_q.pop_front();
            if (got_row !== want.row) begin
                report($sformatf("out_row got %0d want %0d", got_row, want.row));
            end
            if (got_col !== want.col) begin
                report($sformatf("out_col got %0d want %0d", got_col, want.col));
            end
            if (got_dot !== want.dot) begin
                report($sformatf("dot_value at (%0d,%0d) got %0d want %0d", want.row, want.col,
                                 $signed(got_dot), $signed(want.dot)));
            end
            if (m_tlast !== want.last) begin
                report($sformatf("last at (%0d,%0d) got %b want %b", want.row, want.col,
                                 m_tlast, want.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            size_rows  = 4'd3;
            size_inner = 4'd3;
            size_cols  = 4'd5;
            product_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ROWS_A:    size_rows  = cfg_data;
                    REG_INNER_DIM: size_inner = cfg_data;
                    REG_COLS_B:    size_cols  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_WRITE_A:  elems_a[slot] = s_tdata[2*IDX_W +: FIELD_W];
                    ACT_WRITE_B:  elems_b[slot] = s_tdata[2*IDX_W +: FIELD_W];
                    ACT_MULTIPLY: predict_product();
                    default: ;
                endcase
            end
        end
        pending_results <= product_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Testbench top that drives element, multiply and size transfers and prints the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    localparam int MAX_DIM      = 8;
    localparam int LATENCY_PAD  = 8;
    localparam int RANDOM_ITEMS = 310;
    localparam int CYCLE_LIMIT  = 1500000;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    int                   error_count;
    int                   pending_results;

    bit                   steady_tx;
    bit                   steady_rx;
    bit                   written_a [MAX_DIM*MAX_DIM];
    bit                   written_b [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]     size_reg [3] = '{4'd3, 4'd3, 4'd5};
    int unsigned          item_count;
    int unsigned          cycle_count;

    integer_matrix_multiply_top #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (FIELD_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    imm_product_checker #(
        .MAX_DIM (MAX_DIM)
    ) product_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = steady_rx ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            3: return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return DIM_W'(MAX_DIM);
            3: return DIM_W'($urandom_range(MAX_DIM + 1, 14));
            4: return DIM_W'($urandom_range(5, MAX_DIM - 1));
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return d;
    endfunction

    task automatic send_item(input logic [1:0] action, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [FIELD_W-1:0] value);
        int unsigned gap;
        gap = steady_tx ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {{(S_DATA_W - 2*IDX_W - FIELD_W){1'b0}}, value, col, row};
        do @(posedge aclk); while (!s_tready);
        if (action == ACT_WRITE_A) begin
            written_a[{row, col}] = 1'b1;
        end
        if (action == ACT_WRITE_B) begin
            written_b[{row, col}] = 1'b1;
        end
        if (action != ACT_UNUSED) begin
            item_count++;
        end
    endtask

    task automatic write_size(input logic [1:0] index, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index <= REG_COLS_B) begin
            size_reg[index] = value;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    // Sends up to six random element writes, loads every element the next product reads that was
    // never written, refreshes a random share of the others, then issues the multiply.
    task automatic run_product();
        int unsigned m;
        int unsigned k;
        int unsigned p;
        m = eff_dim(size_reg[REG_ROWS_A]);
        k = eff_dim(size_reg[REG_INNER_DIM]);
        p = eff_dim(size_reg[REG_COLS_B]);
        repeat ($urandom_range(0, 6)) begin
            send_item($urandom_range(0, 1) ? ACT_WRITE_B : ACT_WRITE_A,
                      IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)), pick_value());
        end
        for (int r = 0; r < m; r++) begin
            for (int c = 0; c < k; c++) begin
                if (!written_a[r*MAX_DIM + c] || $urandom_range(0, 3) == 0) begin
                    send_item(ACT_WRITE_A, IDX_W'(r), IDX_W'(c), pick_value());
                end
            end
        end
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < p; c++) begin
                if (!written_b[r*MAX_DIM + c] || $urandom_range(0, 3) == 0) begin
                    send_item(ACT_WRITE_B, IDX_W'(r), IDX_W'(c), pick_value());
                end
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), FIELD_W'($urandom));
        end
        send_item(ACT_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), FIELD_W'($urandom));
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_WRITE_A;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ROWS_A;
        cfg_data  <= '0;
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One row of A against two columns of B at full inner size gives the largest positive
        // and the most negative dot products.
        write_size(REG_ROWS_A, 4'd1);
        write_size(REG_INNER_DIM, DIM_W'(MAX_DIM));
        write_size(REG_COLS_B, 4'd2);
        cfg_valid <= 1'b0;
        for (int t = 0; t < MAX_DIM; t++) begin
            send_item(ACT_WRITE_A, '0, IDX_W'(t), 16'h8000);
        end
        for (int t = 0; t < MAX_DIM; t++) begin
            send_item(ACT_WRITE_B, IDX_W'(t), IDX_W'(0), 16'h8000);
            send_item(ACT_WRITE_B, IDX_W'(t), IDX_W'(1), 16'h7FFF);
        end
        send_item(ACT_UNUSED, '1, '1, 16'h7FFF);
        send_item(ACT_WRITE_A, '1, '1, 16'h7FFF);
        send_item(ACT_MULTIPLY, '1, '1, '1);

        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            wait_idle();
            steady_tx = ($urandom_range(0, 3) == 0);
            steady_rx = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) begin
                write_size(REG_UNUSED, pick_size());
            end
            for (int r = 0; r <= REG_COLS_B; r++) begin
                if ($urandom_range(0, 2) != 0) begin
                    write_size(2'(r), pick_size());
                end
            end
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) run_product();
        end

        wait_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/imm_pkg.sv
hdl/integer_matrix_multiply_top.sv
tb/imm_product_checker.sv
tb/tb_top.sv
